FILE: design/cvb_pkg.sv
package cvb_pkg;

  localparam int SAMPLE_W       = 24;
  localparam int ACC_W          = 34;   // 9 taps of 24b x 7b signed
  localparam int DIV_W          = 10;
  localparam int CFG_W          = 63;
  localparam int SIZE_W         = 11;
  localparam int CIDX_W         = 3;
  localparam int KERNEL_SIZE    = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_COEFF_BITS = 7;

  // 128.0 in Q15.8, used for taps outside the image
  localparam logic [SAMPLE_W-1:0] BORDER_RAW = 24'h008000;

  typedef enum logic [CIDX_W-1:0] {
    REG_MASK    = 3'd0,
    REG_NORM    = 3'd1,
    REG_DIVISOR = 3'd2,
    REG_WIDTH   = 3'd3,
    REG_HEIGHT  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_value;
    logic                       frame_last;
    logic                       clipped;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       store;
    logic       start;
    logic       issue;
    logic [1:0] tr;
    logic [1:0] tc;
    logic       div_load;
    logic       div_step;
    logic       load_out;
  } cvb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic accepting;
    logic emit_due;
    logic normalize;
    logic out_free;
  } cvb_stat_t;

endpackage

FILE: design/cvb_stream_if.sv
interface cvb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/cvb_ctrl.sv
module cvb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  input  cvb_pkg::cvb_stat_t stat,
  output cvb_pkg::cvb_cmd_t  cmd
);

  localparam int CNT_W = $clog2(cvb_pkg::ACC_W + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_WAIT, S_DLOAD, S_DIV, S_FIN
  } state_t;

  state_t           state_r;
  logic [1:0]       tr_r;
  logic [1:0]       tc_r;
  logic [CNT_W-1:0] cnt_r;

  // commands decoded from state
  always_comb begin
    cmd      = '0;
    in_ready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.store = stat.accepting && !in_op;
          cmd.start = !stat.accepting || (!in_op && stat.emit_due);
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.tr    = tr_r;
        cmd.tc    = tc_r;
      end
      S_WAIT:  ;
      S_DLOAD: cmd.div_load = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_FIN:   cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tr_r    <= '0;
      tc_r    <= '0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && cmd.start) begin
            state_r <= S_ISSUE;
            tr_r    <= '0;
            tc_r    <= '0;
          end
        end
        S_ISSUE: begin
          if (tc_r == 2'd2) begin
            tc_r <= '0;
            if (tr_r == 2'd2) begin
              state_r <= S_WAIT;
              cnt_r   <= '0;
            end else begin
              tr_r <= tr_r + 2'd1;
            end
          end else begin
            tc_r <= tc_r + 2'd1;
          end
        end
        S_WAIT: begin
          // wait for the read and multiply stages to empty
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= stat.normalize ? S_DLOAD : S_FIN;
          end
        end
        S_DLOAD: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(cvb_pkg::ACC_W - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (stat.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/cvb_dp.sv
module cvb_dp #(
  parameter int MAX_WIDTH  = cvb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cvb_pkg::DEF_MAX_HEIGHT,
  parameter int COEFF_BITS = cvb_pkg::DEF_COEFF_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cvb_pkg::cvb_cmd_t                 cmd,
  input  logic signed [cvb_pkg::SAMPLE_W-1:0] sample,
  input  logic [cvb_pkg::CFG_W-1:0]         cfg_mask,
  input  logic                              cfg_norm,
  input  logic [cvb_pkg::DIV_W-1:0]         cfg_div,
  input  logic [cvb_pkg::SIZE_W-1:0]        cfg_width,
  input  logic [cvb_pkg::SIZE_W-1:0]        cfg_height,
  input  logic                              restart,
  input  logic                              out_ready,
  output logic                              out_valid,
  output cvb_pkg::out_item_t                out_item,
  output cvb_pkg::cvb_stat_t                stat
);

  localparam int SW    = cvb_pkg::SAMPLE_W;
  localparam int AW_A  = cvb_pkg::ACC_W;
  localparam int DW    = cvb_pkg::DIV_W;
  localparam int DEPTH = 2 * MAX_WIDTH + 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
  localparam int N_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int PW    = SW + COEFF_BITS;
  localparam logic [AW:0] DEP = (AW+1)'(DEPTH);
  localparam logic signed [AW_A:0] SAT_HI = (AW_A+1)'((1 <<< (SW - 1)) - 1);
  localparam logic signed [AW_A:0] SAT_LO = ~SAT_HI;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
    logic [AW:0] t;
    t = (v >= DEP) ? (v - DEP) : v;
    return t[AW-1:0];
  endfunction

  // effective frame size and divisor
  logic [COL_W-1:0] w;
  logic [ROW_W-1:0] h;
  logic [DW-1:0]    d;
  always_comb begin
    if (cfg_width == '0)                  w = COL_W'(1);
    else if (32'(cfg_width) > MAX_WIDTH)  w = COL_W'(MAX_WIDTH);
    else                                  w = COL_W'(cfg_width);
    if (cfg_height == '0)                 h = ROW_W'(1);
    else if (32'(cfg_height) > MAX_HEIGHT) h = ROW_W'(MAX_HEIGHT);
    else                                  h = ROW_W'(cfg_height);
    d = (cfg_div == '0) ? DW'(1) : cfg_div;
  end

  logic [COL_W-1:0] in_col_r, out_col_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic [N_W-1:0]   cnt_r;
  logic [AW-1:0]    wp_r, ca_r, rowbase_r;
  logic             last;

  assign last = (out_row_r == h - ROW_W'(1)) && (out_col_r == w - COL_W'(1));

  // frame positions and store pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      cnt_r     <= '0;
      wp_r      <= '0;
      ca_r      <= '0;
    end else if (restart) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      cnt_r     <= '0;
      ca_r      <= wp_r;
    end else begin
      if (cmd.store) begin
        wp_r  <= wrap({1'b0, wp_r} + (AW+1)'(1));
        cnt_r <= cnt_r + N_W'(1);
        if (in_col_r + COL_W'(1) >= w) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + ROW_W'(1);
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
      end
      if (cmd.load_out) begin
        if (last) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
          cnt_r     <= '0;
          ca_r      <= wp_r;
        end else begin
          ca_r <= wrap({1'b0, ca_r} + (AW+1)'(1));
          if (out_col_r + COL_W'(1) >= w) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + ROW_W'(1);
          end else begin
            out_col_r <= out_col_r + COL_W'(1);
          end
        end
      end
    end
  end

  assign stat.accepting = (in_row_r < h);
  assign stat.emit_due  = ({1'b0, cnt_r} >= ((N_W+1)'(w) + (N_W+1)'(1)));
  assign stat.normalize = cfg_norm;
  assign stat.out_free  = !out_valid || out_ready;

  // tap row address: starts one row and one pixel before the center
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rowbase_r <= wrap({1'b0, ca_r} + DEP - (AW+1)'(w) - (AW+1)'(1));
    end else if (cmd.issue && cmd.tc == 2'd2) begin
      rowbase_r <= wrap({1'b0, rowbase_r} + (AW+1)'(w));
    end
  end

  logic [AW-1:0] rd_addr;
  assign rd_addr = wrap({1'b0, rowbase_r} + (AW+1)'(cmd.tc));

  // line store
  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rdata_r;
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[wp_r] <= sample;
    end
    rdata_r <= mem[rd_addr];
  end

  // border check at issue
  logic inb;
  always_comb begin
    inb = 1'b1;
    if (cmd.tr == 2'd0 && out_row_r == '0)              inb = 1'b0;
    if (cmd.tr == 2'd2 && out_row_r == h - ROW_W'(1))   inb = 1'b0;
    if (cmd.tc == 2'd0 && out_col_r == '0)              inb = 1'b0;
    if (cmd.tc == 2'd2 && out_col_r == w - COL_W'(1))   inb = 1'b0;
  end

  // stage 1: read data and tap info; stage 2: product; then accumulate
  logic        v1_r, v2_r, inb1_r;
  logic [3:0]  k1_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [AW_A-1:0] acc_r;
  logic signed [SW-1:0]   tap;
  logic signed [COEFF_BITS-1:0] wgt;

  assign tap = inb1_r ? $signed(rdata_r) : $signed(cvb_pkg::BORDER_RAW);
  assign wgt = $signed(cfg_mask[k1_r * COEFF_BITS +: COEFF_BITS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    inb1_r <= inb;
    k1_r   <= {2'b0, cmd.tr} * 4'(cvb_pkg::KERNEL_SIZE) + {2'b0, cmd.tc};
    prod_r <= PW'(tap * wgt);
    if (cmd.start)  acc_r <= '0;
    else if (v2_r)  acc_r <= acc_r + AW_A'(prod_r);
  end

  // restoring divider on the magnitude, one quotient bit per cycle
  logic [AW_A-1:0] quo_r;
  logic [DW-1:0]   rem_r;
  logic            neg_r;
  logic [DW:0]     trial;
  assign trial = {rem_r, quo_r[AW_A-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_r <= acc_r[AW_A-1];
      quo_r <= acc_r[AW_A-1] ? AW_A'(-acc_r) : AW_A'(acc_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, d}) begin
        rem_r <= DW'(trial - {1'b0, d});
        quo_r <= {quo_r[AW_A-2:0], 1'b1};
      end else begin
        rem_r <= trial[DW-1:0];
        quo_r <= {quo_r[AW_A-2:0], 1'b0};
      end
    end
  end

  // select, saturate
  logic signed [AW_A:0] res;
  logic signed [SW-1:0] sat_val;
  logic                 clip;
  always_comb begin
    if (cfg_norm) res = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    else          res = (AW_A+1)'(acc_r);
    clip    = 1'b0;
    sat_val = SW'(res);
    if (res > SAT_HI) begin
      sat_val = SW'(SAT_HI);
      clip    = 1'b1;
    end else if (res < SAT_LO) begin
      sat_val = SW'(SAT_LO);
      clip    = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.filtered_value <= sat_val;
      out_item.frame_last     <= last;
      out_item.clipped        <= clip;
    end
  end

endmodule

FILE: design/conv3x3_const_border_top.sv
// Channel   Dir  Payload                                  Handshake
// in_s      in   op, sample (Q15.8)                       valid/ready
// out_s     out  filtered_value, frame_last, clipped      valid/ready
// cfg_*     in   cfg_index, cfg_wdata                     cfg_we, no stall
//
// A pixel that yields no result is accepted in S_IDLE. One that yields a result also runs
// 9 line-store reads through a single read port, the read and multiply pipeline stages
// and an output load, plus a 34-step serial divider with normalize set.
// Synchronous active-low reset clears control state; the line store is not
// cleared. A full output register stalls only the final load; the next item
// is accepted while a result waits on out_s.
module conv3x3_const_border_top #(
  parameter int MAX_WIDTH  = cvb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cvb_pkg::DEF_MAX_HEIGHT,
  parameter int COEFF_BITS = cvb_pkg::DEF_COEFF_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cvb_stream_if.sink                  in_s,
  cvb_stream_if.source                out_s,
  input  logic                        cfg_we,
  input  logic [cvb_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [cvb_pkg::CFG_W-1:0]   cfg_wdata
);

  logic [cvb_pkg::CFG_W-1:0]  mask_r;
  logic                       norm_r;
  logic [cvb_pkg::DIV_W-1:0]  div_r;
  logic [cvb_pkg::SIZE_W-1:0] width_r, height_r;
  logic                       restart;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      norm_r   <= 1'b0;
      div_r    <= cvb_pkg::DIV_W'(1);
      width_r  <= cvb_pkg::SIZE_W'(1024);
      height_r <= cvb_pkg::SIZE_W'(1024);
    end else if (cfg_we) begin
      unique case (cvb_pkg::cfg_idx_t'(cfg_index))
        cvb_pkg::REG_MASK:    mask_r   <= cfg_wdata;
        cvb_pkg::REG_NORM:    norm_r   <= cfg_wdata[0];
        cvb_pkg::REG_DIVISOR: div_r    <= cfg_wdata[cvb_pkg::DIV_W-1:0];
        cvb_pkg::REG_WIDTH:   width_r  <= cfg_wdata[cvb_pkg::SIZE_W-1:0];
        cvb_pkg::REG_HEIGHT:  height_r <= cfg_wdata[cvb_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // a size write restarts the frame
  assign restart = cfg_we &&
                   ((cfg_index == cvb_pkg::REG_WIDTH) || (cfg_index == cvb_pkg::REG_HEIGHT));

  cvb_pkg::cvb_cmd_t  cmd;
  cvb_pkg::cvb_stat_t stat;

  cvb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_op    (in_s.data.op),
    .in_ready (in_s.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cvb_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COEFF_BITS (COEFF_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample     (in_s.data.sample),
    .cfg_mask   (mask_r),
    .cfg_norm   (norm_r),
    .cfg_div    (div_r),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .restart    (restart),
    .out_ready  (out_s.ready),
    .out_valid  (out_s.valid),
    .out_item   (out_s.data),
    .stat       (stat)
  );

endmodule

FILE: tb/conv3x3_const_border_top_tb.sv
`timescale 1ns / 1ps

module conv3x3_const_border_top_tb;

  localparam int STORE_DEPTH = 2 * cvb_pkg::DEF_MAX_WIDTH + 4;
  localparam int NUM_RAND = 1200;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE = 100;
  localparam logic [cvb_pkg::CIDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [cvb_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [cvb_pkg::CFG_W-1:0] cfg_wdata = '0;

  cvb_stream_if #(.T(cvb_pkg::in_item_t)) in_if ();
  cvb_stream_if #(.T(cvb_pkg::out_item_t)) out_if ();

  conv3x3_const_border_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_s(in_if),
    .out_s(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  // filter state mirror
  logic [cvb_pkg::CFG_W-1:0] mask_r = '0;
  logic norm_r = 1'b0;
  logic [cvb_pkg::DIV_W-1:0] div_r = 1;
  logic [cvb_pkg::SIZE_W-1:0] width_r = 1024;
  logic [cvb_pkg::SIZE_W-1:0] height_r = 1024;
  logic [cvb_pkg::SAMPLE_W-1:0] pixel_hist [STORE_DEPTH];
  int unsigned in_col, in_row, out_col, out_row;

  cvb_pkg::in_item_t pixel_q[$];
  cvb_pkg::out_item_t filtered_q[$];
  int errors = 0;
  int n_results = 0;
  int n_clipped = 0;
  int n_frames = 0;
  int n_items = 0;
  bit burst = 1'b0;

  function automatic int unsigned eff_dim(logic [cvb_pkg::SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > cvb_pkg::DEF_MAX_WIDTH) return cvb_pkg::DEF_MAX_WIDTH;
    return 32'(v);
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void apply_reg(logic [cvb_pkg::CIDX_W-1:0] idx,
                                    logic [cvb_pkg::CFG_W-1:0] val);
    case (idx)
      cvb_pkg::REG_MASK:    mask_r = val;
      cvb_pkg::REG_NORM:    norm_r = val[0];
      cvb_pkg::REG_DIVISOR: div_r = val[cvb_pkg::DIV_W-1:0];
      cvb_pkg::REG_WIDTH: begin
        width_r = val[cvb_pkg::SIZE_W-1:0];
        restart_frame();
      end
      cvb_pkg::REG_HEIGHT: begin
        height_r = val[cvb_pkg::SIZE_W-1:0];
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  // weighted 3x3 sum at the output position, queued as the next expected result
  function automatic void produce_filtered();
    int unsigned w, h, idx;
    int rr, cc, k;
    longint acc, tap, wgt, d;
    cvb_pkg::out_item_t r;
    w = eff_dim(width_r);
    h = eff_dim(height_r);
    acc = 0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        rr = int'(out_row) + dr - 1;
        cc = int'(out_col) + dc - 1;
        k = dr * 3 + dc;
        wgt = longint'($signed(mask_r[k*cvb_pkg::DEF_COEFF_BITS +: cvb_pkg::DEF_COEFF_BITS]));
        tap = longint'($signed(cvb_pkg::BORDER_RAW));
        if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
          idx = (rr * w + cc) % STORE_DEPTH;
          tap = longint'($signed(pixel_hist[idx]));
        end
        acc += tap * wgt;
      end
    end
    if (norm_r) begin
      d = (div_r == 0) ? 1 : longint'(div_r);
      acc = acc / d;
    end
    r.clipped = 1'b0;
    if (acc > 8388607) begin
      acc = 8388607;
      r.clipped = 1'b1;
    end
    if (acc < -8388608) begin
      acc = -8388608;
      r.clipped = 1'b1;
    end
    r.filtered_value = acc[cvb_pkg::SAMPLE_W-1:0];
    r.frame_last = (out_row == h - 1) && (out_col == w - 1);
    filtered_q = {filtered_q, r};
    if (r.frame_last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  function automatic void take_pixel(cvb_pkg::in_item_t it);
    int unsigned w, h, n;
    w = eff_dim(width_r);
    h = eff_dim(height_r);
    if (in_row < h) begin
      if (it.op == OP_DRAIN) return;
      n = in_row * w + in_col;
      pixel_hist[n % STORE_DEPTH] = it.sample;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (n >= w + 1) produce_filtered();
    end else begin
      produce_filtered();
    end
  endfunction

  // input driver: gaps drawn per transaction
  bit in_taken = 1'b0;
  int in_gap = 0;
  always @(negedge clk) begin
    cvb_pkg::in_item_t nxt;
    logic nv;
    nxt = in_if.data;
    nv = in_if.valid;
    if (!in_if.valid || in_taken) begin
      in_taken = 1'b0;
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pixel_q.size() > 0) begin
        nxt = pixel_q.pop_front();
        nv = 1'b1;
        in_gap = burst ? 0 : $urandom_range(0, 6);
      end
    end
    in_if.valid <= nv;
    in_if.data <= nxt;
  end

  // output sink: stall drawn per transaction
  int out_stall = 0;
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // acceptance, checking and watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    cvb_pkg::out_item_t e, a;
    if (in_if.valid && in_if.ready) begin
      in_taken = 1'b1;
      take_pixel(in_if.data);
    end
    if (out_if.valid && out_if.ready) begin
      a = out_if.data;
      out_stall = burst ? 0 : $urandom_range(0, 6);
      if (filtered_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, a);
      end else begin
        e = filtered_q.pop_front();
        n_results++;
        if (a.clipped) n_clipped++;
        if (a.filtered_value !== e.filtered_value) begin
          errors++;
          $display("%0t: filtered_value exp %h got %h", $time, e.filtered_value,
                   a.filtered_value);
        end
        if (a.frame_last !== e.frame_last) begin
          errors++;
          $display("%0t: frame_last exp %b got %b", $time, e.frame_last, a.frame_last);
        end
        if (a.clipped !== e.clipped) begin
          errors++;
          $display("%0t: clipped exp %b got %b", $time, e.clipped, a.clipped);
        end
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("** conv3x3_const_border_top: FAILED **");
      $finish;
    end
  end

  task automatic push_item(logic op, logic [cvb_pkg::SAMPLE_W-1:0] s);
    cvb_pkg::in_item_t it;
    it.op = op;
    it.sample = s;
    pixel_q = {pixel_q, it};
    n_items++;
  endtask

  function automatic logic [cvb_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2, 3, 4: return 24'($urandom());
      default: return 24'($urandom_range(0, 131071)) - 24'd65536;
    endcase
  endfunction

  function automatic logic [cvb_pkg::CFG_W-1:0] fill_mask(
      logic [cvb_pkg::DEF_COEFF_BITS-1:0] c);
    logic [cvb_pkg::CFG_W-1:0] m;
    for (int k = 0; k < 9; k++) m[k*cvb_pkg::DEF_COEFF_BITS +: cvb_pkg::DEF_COEFF_BITS] = c;
    return m;
  endfunction

  task automatic wait_idle();
    wait (pixel_q.size() == 0 && !in_if.valid && filtered_q.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [cvb_pkg::CIDX_W-1:0] idx, logic [cvb_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(logic [cvb_pkg::CFG_W-1:0] m, logic nrm,
                       logic [cvb_pkg::DIV_W-1:0] dv,
                       logic [cvb_pkg::SIZE_W-1:0] w, logic [cvb_pkg::SIZE_W-1:0] h);
    wait_idle();
    write_reg(cvb_pkg::REG_MASK, m);
    write_reg(cvb_pkg::REG_NORM, cvb_pkg::CFG_W'(nrm));
    write_reg(cvb_pkg::REG_DIVISOR, cvb_pkg::CFG_W'(dv));
    write_reg(cvb_pkg::REG_WIDTH, cvb_pkg::CFG_W'(w));
    write_reg(cvb_pkg::REG_HEIGHT, cvb_pkg::CFG_W'(h));
  endtask

  // one frame: pixels with stray drains, then the ticks that flush owed results;
  // a broken frame stops partway and is cut short by the next size write
  task automatic send_frame(bit broken);
    int unsigned w, h, total, owed, stop;
    w = eff_dim(width_r);
    h = eff_dim(height_r);
    total = w * h;
    stop = broken ? $urandom_range(1, total) : total;
    for (int unsigned i = 0; i < stop; i++) begin
      if ($urandom_range(0, 99) < 8) push_item(OP_DRAIN, cvb_pkg::SAMPLE_W'($urandom()));
      push_item(OP_PIXEL, rand_sample());
    end
    if (broken) return;
    owed = (total < w + 1) ? total : w + 1;
    for (int unsigned i = 0; i < owed; i++) begin
      if ($urandom_range(0, 9) < 7) push_item(OP_DRAIN, cvb_pkg::SAMPLE_W'($urandom()));
      else push_item(OP_PIXEL, cvb_pkg::SAMPLE_W'($urandom()));
    end
    if ($urandom_range(0, 9) == 0) push_item(OP_DRAIN, cvb_pkg::SAMPLE_W'($urandom()));
    n_frames++;
  endtask

  initial begin
    bit broken;
    restart_frame();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: 3x3 frame of extreme samples, all weights at +max
    setup(fill_mask(7'h3F), 1'b0, 10'd1, 11'd3, 11'd3);
    push_item(OP_DRAIN, 24'h0);
    push_item(OP_PIXEL, 24'h7FFFFF);
    push_item(OP_PIXEL, 24'h800000);
    push_item(OP_PIXEL, 24'h000000);
    push_item(OP_DRAIN, 24'hFFFFFF);
    push_item(OP_PIXEL, 24'h000001);
    push_item(OP_PIXEL, 24'hFFFFFF);
    push_item(OP_PIXEL, 24'h7FFFFF);
    push_item(OP_PIXEL, 24'h800000);
    push_item(OP_PIXEL, 24'h7FFFFF);
    push_item(OP_PIXEL, 24'h7FFFFF);
    push_item(OP_DRAIN, 24'h0);
    push_item(OP_PIXEL, 24'h123456);
    push_item(OP_DRAIN, 24'h0);
    push_item(OP_DRAIN, 24'h0);

    // zero sizes mean 1x1, zero divisor means 1, unmapped index is dropped
    setup(fill_mask(7'h40), 1'b1, 10'd0, 11'd0, 11'd0);
    write_reg(REG_UNMAPPED, '1);
    push_item(OP_PIXEL, 24'h800000);
    push_item(OP_DRAIN, 24'h0);

    // size write mid-frame restarts it
    setup(cvb_pkg::CFG_W'({$urandom(), $urandom()}), 1'b1, 10'd567, 11'd4, 11'd4);
    push_item(OP_PIXEL, 24'h000100);
    push_item(OP_PIXEL, 24'h7FFFFF);
    push_item(OP_PIXEL, 24'h800000);
    wait_idle();
    write_reg(cvb_pkg::REG_WIDTH, cvb_pkg::CFG_W'(11'd4));
    send_frame(1'b0);

    // random frames, mostly small
    broken = 1'b0;
    while (n_items < NUM_RAND) begin
      if (broken || $urandom_range(0, 2) == 0) begin
        setup(cvb_pkg::CFG_W'({$urandom(), $urandom()}), 1'($urandom()),
              ($urandom_range(0, 3) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 567)),
              ($urandom_range(0, 9) == 0) ? 11'($urandom_range(9, 24))
                                          : 11'($urandom_range(1, 8)),
              11'($urandom_range(1, 6)));
        burst = ($urandom_range(0, 3) == 0);
      end
      broken = ($urandom_range(0, 9) == 0);
      send_frame(broken);
    end

    wait (pixel_q.size() == 0 && !in_if.valid && filtered_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d input transactions over %0d full frames", n_items, n_frames);
    $display("Checked %0d filtered results, %0d saturated", n_results, n_clipped);
    if (errors == 0) begin
      $display("** conv3x3_const_border_top: PASSED **");
    end else begin
      $display("** conv3x3_const_border_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: conv3x3_const_border_top.f
design/cvb_pkg.sv
design/cvb_stream_if.sv
design/cvb_ctrl.sv
design/cvb_dp.sv
design/conv3x3_const_border_top.sv
tb/conv3x3_const_border_top_tb.sv
